// ===== rtl/core/pfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the page frame replacement policy unit.
package pfr_pkg;

   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic mark;
   } ctrl_type;

endpackage

// ===== rtl/core/page_frame_replacement_policy_unit.sv =====
`timescale 1ns / 1ps
// Top level: FIFO / second-chance page replacement over a chain of frame cells.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser cmd, tdata page_number
//  rsp     | out | rsp_tvalid/tready    | tdata victim_valid, victim_page, hit, count
//  csr     | in  | csr_valid/csr_ready  | csr_data policy_mode
//
// Reference beats and places into a non-full table are answered without entering the scan state.
// A place into a full table in second-chance mode rotates one referenced page
// per cycle through the cell chain until an unreferenced page is evicted.
// Reset clears all valid and referenced bits at once; mode resets to second-chance.
// A result waiting in the output register stalls only the next beat's acceptance.
module page_frame_replacement_policy_unit #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 20
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic                                            req_tuser,  // [0] cmd
   input  logic [((PAGE_BITS+7)/8)*8-1:0]                  req_tdata,  // page_number
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // victim_valid, victim_page, hit, resident_count (5)
   output logic [((PAGE_BITS+pfr_pkg::COUNT_W+2+7)/8)*8-1:0] rsp_tdata,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic                                            csr_data    // policy_mode
);

   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int RSP_W = ((PAGE_BITS + pfr_pkg::COUNT_W + 2 + 7) / 8) * 8;

   pfr_pkg::state_type   state_ff, state_in;
   pfr_pkg::ctrl_type    ctrl;
   logic                 mode_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PAGE_BITS-1:0] key_ff;
   logic [PAGE_BITS-1:0] key;
   logic [PAGE_BITS-1:0] tail_page;

   logic                 rsp_valid_ff;
   logic                 rsp_vv_ff, rsp_vv_in;
   logic [PAGE_BITS-1:0] rsp_page_ff, rsp_page_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]     rsp_cnt_ff;
   logic                 rsp_write;

   logic [PAGE_BITS-1:0] cell_page  [FRAMES];
   logic                 cell_ref   [FRAMES];
   logic                 cell_valid [FRAMES];
   logic [FRAMES-1:0]    cell_match;
   logic [FRAMES-1:0]    load_sel;

   logic accept, scan, full, place, rotate, evict;

   assign csr_ready  = 1'b1;
   assign scan       = (state_ff == pfr_pkg::ST_SCAN);
   assign req_tready = (state_ff == pfr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(FRAMES));
   assign place      = accept && !req_tuser;
   assign key        = scan ? key_ff : req_tdata[PAGE_BITS-1:0];

   assign rotate = (place && full && mode_ff && cell_ref[0]) || (scan && cell_ref[0]);
   assign evict  = (place && full && (!mode_ff || !cell_ref[0])) || (scan && !cell_ref[0]);

   assign ctrl.shift = rotate || evict;
   assign ctrl.load  = place && !full;
   assign ctrl.mark  = accept && req_tuser;
   assign tail_page  = rotate ? cell_page[0] : key;

   genvar gi;
   generate
      for (gi = 0; gi < FRAMES; gi++) begin : g_cell
         logic [PAGE_BITS-1:0] nxt_page;
         logic                 nxt_ref;
         logic                 nxt_valid;
         if (gi == FRAMES - 1) begin : g_tail
            assign nxt_page  = tail_page;
            assign nxt_ref   = 1'b0;
            assign nxt_valid = 1'b1;
         end else begin : g_body
            assign nxt_page  = cell_page[gi+1];
            assign nxt_ref   = cell_ref[gi+1];
            assign nxt_valid = cell_valid[gi+1];
         end
         assign load_sel[gi] = (count_ff == CNT_W'(gi));
         pfr_cell #(
            .PAGE_BITS (PAGE_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .load_sel  (load_sel[gi]),
            .key       (key),
            .nxt_page  (nxt_page),
            .nxt_ref   (nxt_ref),
            .nxt_valid (nxt_valid),
            .page      (cell_page[gi]),
            .ref_bit   (cell_ref[gi]),
            .valid     (cell_valid[gi]),
            .match     (cell_match[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfr_pkg::ST_IDLE: begin
            if (place && full && mode_ff && cell_ref[0]) state_in = pfr_pkg::ST_SCAN;
         end
         pfr_pkg::ST_SCAN: begin
            if (!cell_ref[0]) state_in = pfr_pkg::ST_IDLE;
         end
         default: state_in = pfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in    = ctrl.load ? count_ff + CNT_W'(1) : count_ff;
      rsp_write   = ctrl.mark || ctrl.load || evict;
      rsp_vv_in   = evict;
      rsp_page_in = evict ? cell_page[0] : '0;
      rsp_hit_in  = ctrl.mark && (|cell_match);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfr_pkg::ST_IDLE;
         mode_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid) mode_ff <= csr_data;
         if (rsp_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) key_ff <= req_tdata[PAGE_BITS-1:0];
      if (rsp_write) begin
         rsp_vv_ff   <= rsp_vv_in;
         rsp_page_ff <= rsp_page_in;
         rsp_hit_ff  <= rsp_hit_in;
         rsp_cnt_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({pfr_pkg::COUNT_W'(rsp_cnt_ff), rsp_hit_ff, rsp_page_ff,
                               rsp_vv_ff});

endmodule

// ===== rtl/core/pfr_cell.sv =====
`timescale 1ns / 1ps
// One frame slot: page number, referenced bit and valid bit, shifting toward the old end.
module pfr_cell #(
   parameter int PAGE_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfr_pkg::ctrl_type    ctrl,
   input  logic                 load_sel,
   input  logic [PAGE_BITS-1:0] key,
   input  logic [PAGE_BITS-1:0] nxt_page,
   input  logic                 nxt_ref,
   input  logic                 nxt_valid,
   output logic [PAGE_BITS-1:0] page,
   output logic                 ref_bit,
   output logic                 valid,
   output logic                 match
);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 ref_ff;
   logic                 valid_ff;

   assign match   = valid_ff && (page_ff == key);
   assign page    = page_ff;
   assign ref_bit = ref_ff;
   assign valid   = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ref_ff   <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= nxt_valid;
         ref_ff   <= nxt_ref;
      end else if (ctrl.load && load_sel) begin
         valid_ff <= 1'b1;
         ref_ff   <= 1'b0;
      end else if (ctrl.mark && match) begin
         ref_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         page_ff <= nxt_page;
      end else if (ctrl.load && load_sel) begin
         page_ff <= key;
      end
   end

endmodule
